>>> rtl/rde_pkg.sv
// Shared types, constants and the symbol function for the radix digit encoder.
// No dependencies; every other file in the block imports this package.
`default_nettype none

package rde_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int MAX_RADIX   = 62;
    localparam int STACK_DEPTH = 64;
    localparam int RADIX_BITS  = 6;
    localparam int DIGIT_BITS  = 6;
    localparam int SYMBOL_BITS = 7;
    localparam int CNT_BITS    = $clog2(VALUE_BITS);
    localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
    localparam int COUNT_BITS  = ADDR_BITS + 1;

    localparam logic [SYMBOL_BITS-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [SYMBOL_BITS-1:0] ASCII_LOWER = 7'h61;
    localparam logic [SYMBOL_BITS-1:0] ASCII_UPPER = 7'h41;

    typedef struct packed {
        logic [63:0] number;
        logic [7:0]  radix;
    } t_in_item;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic                   last_symbol;
        logic                   bad_radix;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                  load;
        logic                  go;
        logic [VALUE_BITS-1:0] number;
        logic [RADIX_BITS-1:0] base;
    } t_div_ctrl;

    typedef struct packed {
        logic                  done;
        logic                  nonzero;
        logic [DIGIT_BITS-1:0] rem;
    } t_div_stat;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_BITS-1:0]  wr_addr;
        logic [DIGIT_BITS-1:0] wr_data;
        logic                  rd_en;
        logic [ADDR_BITS-1:0]  rd_addr;
    } t_stack_req;

    function automatic logic [SYMBOL_BITS-1:0] digit_to_ascii(
        input logic [DIGIT_BITS-1:0] d
    );
        logic [SYMBOL_BITS-1:0] dx;
        dx = {1'b0, d};
        if (d < 6'd10) begin
            return ASCII_ZERO + dx;
        end else if (d < 6'd36) begin
            return ASCII_LOWER + dx - 7'd10;
        end else begin
            return ASCII_UPPER + dx - 7'd36;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/rde_divider.sv
// Bit-serial restoring divider: divides the held quotient by a small base, one bit a cycle.
// Depends on rde_pkg.
`default_nettype none

module rde_divider
    import rde_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_div_ctrl i_ctrl,
    output t_div_stat      o_stat
);

    localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(VALUE_BITS - 1);

    logic [VALUE_BITS-1:0] r_quot, n_quot;
    logic [RADIX_BITS-1:0] r_base;
    logic [DIGIT_BITS-1:0] r_rem, n_rem;
    logic                  r_nz, n_nz;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_run;
    logic                  r_done;

    logic [DIGIT_BITS:0]   w_trial;
    logic [DIGIT_BITS:0]   w_diff;
    logic                  w_ge;

    // The partial remainder stays below the base, so the trial value is at most
    // one bit wider and the difference always fits back into the remainder.
    always_comb begin
        w_trial = {r_rem, r_quot[VALUE_BITS-1]};
        w_ge    = (w_trial >= {1'b0, r_base});
        w_diff  = w_trial - {1'b0, r_base};
        n_rem   = w_ge ? w_diff[DIGIT_BITS-1:0] : w_trial[DIGIT_BITS-1:0];
        n_quot  = {r_quot[VALUE_BITS-2:0], w_ge};
        n_nz    = r_nz | w_ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_quot <= i_ctrl.number;
            r_base <= i_ctrl.base;
        end else if (r_run) begin
            r_quot <= n_quot;
        end
        if (i_ctrl.go) begin
            r_rem <= '0;
            r_nz  <= 1'b0;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_nz  <= n_nz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == LAST_CNT) && !i_ctrl.go;
            if (i_ctrl.go) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    assign o_stat.done    = r_done;
    assign o_stat.nonzero = r_nz;
    assign o_stat.rem     = r_rem;

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_base))
        else $error("remainder not below base at end of division");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run)
        else $error("division still running when reported done");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> !i_ctrl.go)
        else $error("division restarted while running");

endmodule

`default_nettype wire

>>> rtl/rde_digit_stack.sv
// Digit stack: 64 six-bit entries, one write and one registered read per cycle.
// Depends on rde_pkg.
`default_nettype none

module rde_digit_stack
    import rde_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_stack_req i_req,
    output logic [DIGIT_BITS-1:0] o_rd_data
);

    logic [DIGIT_BITS-1:0] r_mem [STACK_DEPTH];
    logic [DIGIT_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/radix_digit_encoder_top.sv
// Top level of the radix digit encoder: sequencer, divider and digit stack.
// Depends on rde_pkg, rde_divider and rde_digit_stack.
//
//   Port      Dir  Payload     Handshake
//   start     in   i_item      taken when start is high and busy is low
//   o_valid   out  o_result    one-cycle strobe, always taken
//
// Each digit comes from the bit-serial divider, one quotient bit per cycle,
// then each symbol is popped from the stack through the READ and EMIT states;
// an item has at most 64 digits.
// A rejected base gives its single result the cycle after acceptance.
// Reset is synchronous and active low; the stack needs no clearing.
// Results cannot be held off, so nothing stalls once an item is taken.
`default_nettype none

module radix_digit_encoder_top
    import rde_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_in_item  i_item,
    output logic           busy,
    output logic           o_valid,
    output t_out_item      o_result
);

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_valid, n_valid;
    t_out_item             r_result, n_result;

    t_div_ctrl             w_div_ctrl;
    t_div_stat             w_div_stat;
    t_stack_req            w_stack_req;
    logic [DIGIT_BITS-1:0] w_rd_data;

    logic                  w_accept;
    logic                  w_radix_ok;
    logic [COUNT_BITS-1:0] w_count_dec;

    assign w_accept    = start && (r_state == ST_IDLE);
    assign w_radix_ok  = i_item.radix inside {[8'd2 : 8'(MAX_RADIX)]};
    assign w_count_dec = r_count - 1'b1;

    rde_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_div_ctrl),
        .o_stat  (w_div_stat)
    );

    rde_digit_stack u_stack (
        .i_clk     (i_clk),
        .i_req     (w_stack_req),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_radix_ok) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (w_div_stat.done && !w_div_stat.nonzero) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_state = (r_count == '0) ? ST_IDLE : ST_READ;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count              = r_count;
        n_valid              = 1'b0;
        n_result             = '0;
        w_div_ctrl           = '0;
        w_div_ctrl.number    = i_item.number[VALUE_BITS-1:0];
        w_div_ctrl.base      = i_item.radix[RADIX_BITS-1:0];
        w_stack_req          = '0;
        w_stack_req.wr_addr  = r_count[ADDR_BITS-1:0];
        w_stack_req.wr_data  = w_div_stat.rem;
        w_stack_req.rd_addr  = w_count_dec[ADDR_BITS-1:0];
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_radix_ok) begin
                        w_div_ctrl.load = 1'b1;
                        w_div_ctrl.go   = 1'b1;
                        n_count         = '0;
                    end else begin
                        n_valid              = 1'b1;
                        n_result.last_symbol = 1'b1;
                        n_result.bad_radix   = 1'b1;
                    end
                end
            end
            ST_DIVIDE: begin
                if (w_div_stat.done) begin
                    // Digits go on the stack least significant first.
                    w_stack_req.wr_en = 1'b1;
                    n_count           = r_count + 1'b1;
                    w_div_ctrl.go     = w_div_stat.nonzero;
                end
            end
            ST_READ: begin
                w_stack_req.rd_en = 1'b1;
                n_count           = w_count_dec;
            end
            ST_EMIT: begin
                n_valid              = 1'b1;
                n_result.symbol      = digit_to_ascii(w_rd_data);
                n_result.last_symbol = (r_count == '0);
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(STACK_DEPTH))
        else $error("digit count beyond stack depth");

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.bad_radix) |-> (o_result.last_symbol && o_result.symbol == '0))
        else $error("rejected item result malformed");

    a_symbol_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.bad_radix) |-> (o_result.symbol != '0))
        else $error("digit result without a symbol");

    a_emit_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_count != '0))
        else $error("stack popped while empty");

endmodule

`default_nettype wire
